>>> rtl/core/prc_pkg.sv
// Shared types, constants and helpers for the printable rotor cipher.
// No dependencies.
package prc_pkg;

  localparam int unsigned RingSize  = 94;
  localparam logic [6:0]  RingLast  = 7'd93;
  localparam logic [7:0]  RingMod   = 8'd94;
  localparam logic [14:0] SeedInit  = 15'd123;
  localparam logic [3:0]  KeyLast   = 4'd12;
  localparam logic [14:0] RecipMul  = 15'd22310;  // floor(2^21 / 94)
  localparam int unsigned RecipShift = 21;
  localparam logic [7:0]  PrintLo   = 8'd32;
  localparam logic [7:0]  PrintHi   = 8'd125;

  localparam logic        OpRekey   = 1'b0;
  localparam logic        OpXform   = 1'b1;

  localparam logic [1:0]  CfgKeyLow  = 2'd0;
  localparam logic [1:0]  CfgKeyHigh = 2'd1;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_char;
  } prc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       passed_through;
  } prc_out_t;

  typedef struct packed {
    logic init;
    logic mix;
    logic draw;
  } prc_draw_cmd_t;

  // wrap a value below 2*94 back onto the ring
  function automatic logic [6:0] ring_wrap(input logic [7:0] x);
    logic [7:0] r;
    r = (x >= RingMod) ? (x - RingMod) : x;
    return r[6:0];
  endfunction

endpackage

>>> rtl/core/prc_ram.sv
// Simple dual-port table RAM with registered read data.
// No dependencies.
module prc_ram #(
  parameter int unsigned DEPTH = 94,
  parameter int unsigned WIDTH = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/prc_draw.sv
// Key schedule seed generator: seed mixing and draws reduced mod 94.
// Depends on prc_pkg.
module prc_draw import prc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  prc_draw_cmd_t cmd_i,
  input  logic [7:0]    key_byte_i,
  input  logic [3:0]    idx_i,
  output logic          done_o,
  output logic [6:0]    k_o
);

  logic [14:0] seed_q, seed_d;
  logic [29:0] prod_q;
  logic        st1_q, st2_q, done_q;
  logic [6:0]  k_q;
  logic [8:0]  quot;
  logic [15:0] rem;
  logic [15:0] rem_fix;

  always_comb begin
    seed_d = seed_q;
    if (cmd_i.init) begin
      seed_d = SeedInit;
    end else if (cmd_i.mix) begin
      seed_d = 15'(23'(seed_q) * 23'(key_byte_i) + 23'(idx_i));
    end else if (cmd_i.draw) begin
      seed_d = 15'(18'(seed_q) * 18'd5 + 18'(key_byte_i));
    end
  end

  assign quot    = prod_q[RecipShift +: 9];
  assign rem     = 16'(seed_q) - 16'(quot) * 16'(RingMod);
  assign rem_fix = (rem >= 16'(RingMod)) ? (rem - 16'(RingMod)) : rem;

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
    if (st1_q) begin
      prod_q <= 30'(seed_q) * 30'(RecipMul);
    end
    if (st2_q) begin
      k_q <= rem_fix[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q  <= 1'b0;
      st2_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st1_q  <= cmd_i.draw;
      st2_q  <= st1_q;
      done_q <= st2_q;
    end
  end

  assign done_o = done_q;
  assign k_o    = k_q;

endmodule

>>> rtl/core/printable_rotor_cipher.sv
// Top level of the printable rotor cipher: sequencer, state and table RAMs.
// Depends on prc_pkg, prc_ram and prc_draw.
//
//  port group   dir  signals                          payload
//  input        in   in_valid_i / in_stall_o          prc_in_t  in_data_i
//  output       out  out_valid_o / out_stall_i        prc_out_t out_data_o
//  config       in   cfg_we_i, cfg_idx_i, cfg_data_i  key bytes, 64 + 40 bits
//
// Transform: the result is set by the serial chain of table reads through
// registered-read RAMs.
// Byte outside 32..125: result valid the cycle after accept, no stepping.
// Rekey: a draw-and-swap per entry through simple dual-port table RAMs.
// One item in flight; in_stall_o is high until the result beat leaves.
// Reset clears control, key and state.
module printable_rotor_cipher import prc_pkg::*; #(
  parameter int unsigned NUM_ROTORS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  prc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output prc_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned RotDepth = NUM_ROTORS * RingSize;
  localparam int unsigned RAW      = $clog2(RotDepth);
  localparam int unsigned JW       = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;
  localparam logic [JW-1:0]  JLast    = JW'(NUM_ROTORS - 1);
  localparam logic [RAW-1:0] RowStep  = RAW'(RingSize);
  localparam logic [RAW-1:0] LastBase = RAW'((NUM_ROTORS - 1) * RingSize);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_MIX   = 5'd1;
  localparam logic [4:0] ST_FILL  = 5'd2;
  localparam logic [4:0] ST_SDRAW = 5'd3;
  localparam logic [4:0] ST_SWAIT = 5'd4;
  localparam logic [4:0] ST_SRA   = 5'd5;
  localparam logic [4:0] ST_SRB   = 5'd6;
  localparam logic [4:0] ST_SWA   = 5'd7;
  localparam logic [4:0] ST_SWB   = 5'd8;
  localparam logic [4:0] ST_RRA   = 5'd9;
  localparam logic [4:0] ST_RRB   = 5'd10;
  localparam logic [4:0] ST_RRC   = 5'd11;
  localparam logic [4:0] ST_RRD   = 5'd12;
  localparam logic [4:0] ST_RWA   = 5'd13;
  localparam logic [4:0] ST_RWB   = 5'd14;
  localparam logic [4:0] ST_RFILL = 5'd15;
  localparam logic [4:0] ST_INVA  = 5'd16;
  localparam logic [4:0] ST_INVB  = 5'd17;
  localparam logic [4:0] ST_TF    = 5'd18;
  localparam logic [4:0] ST_TFD   = 5'd19;
  localparam logic [4:0] ST_TR    = 5'd20;
  localparam logic [4:0] ST_TRD   = 5'd21;
  localparam logic [4:0] ST_TB    = 5'd22;
  localparam logic [4:0] ST_TBD   = 5'd23;
  localparam logic [4:0] ST_OUT   = 5'd24;

  logic [4:0]     state_q, state_d;
  logic [6:0]     i_q, i_d;
  logic [6:0]     k_q, k_d;
  logic [6:0]     a_q, a_d;
  logic [6:0]     b_q, b_d;
  logic [6:0]     v_q, v_d;
  logic [3:0]     kidx_q, kidx_d;
  logic [JW-1:0]  j_q, j_d;
  logic [RAW-1:0] base_q, base_d;
  logic           sel_rot_q, sel_rot_d;
  logic           keyed_q, keyed_d;
  logic [6:0]     pos_q [NUM_ROTORS];
  logic [6:0]     pos_d [NUM_ROTORS];
  logic [6:0]     ph_q, ph_d;
  logic [63:0]    key_lo_q;
  logic [39:0]    key_hi_q;
  prc_out_t       out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic [103:0]   key_all;
  logic [7:0]     key_byte;
  prc_draw_cmd_t  draw_cmd;
  logic           draw_done;
  logic [6:0]     draw_k;

  logic           sv_we, refl_we, rot_we, inv_we;
  logic [6:0]     sv_waddr, sv_wdata, sv_raddr, sv_rdata;
  logic [6:0]     refl_waddr, refl_wdata, refl_raddr, refl_rdata;
  logic [RAW-1:0] rot_waddr, rot_raddr, inv_waddr, inv_raddr;
  logic [6:0]     rot_wdata, rot_rdata, inv_wdata, inv_rdata;
  logic [6:0]     swap_rdata;
  logic [6:0]     pos_j;
  logic [6:0]     tmp;
  logic           carry;
  logic           in_fire;

  assign key_all  = {key_hi_q, key_lo_q};
  assign key_byte = key_all[{kidx_q, 3'b000} +: 8];
  assign in_fire  = in_valid_i && !in_stall_o;
  assign swap_rdata = sel_rot_q ? rot_rdata : sv_rdata;
  assign pos_j    = pos_q[j_q];

  prc_draw u_draw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (draw_cmd),
    .key_byte_i (key_byte),
    .idx_i      (kidx_q),
    .done_o     (draw_done),
    .k_o        (draw_k)
  );

  prc_ram #(.DEPTH(RingSize), .WIDTH(7)) u_sv (
    .clk_i(clk_i), .we_i(sv_we), .waddr_i(sv_waddr), .wdata_i(sv_wdata),
    .raddr_i(sv_raddr), .rdata_o(sv_rdata)
  );

  prc_ram #(.DEPTH(RingSize), .WIDTH(7)) u_refl (
    .clk_i(clk_i), .we_i(refl_we), .waddr_i(refl_waddr), .wdata_i(refl_wdata),
    .raddr_i(refl_raddr), .rdata_o(refl_rdata)
  );

  prc_ram #(.DEPTH(RotDepth), .WIDTH(7)) u_rot (
    .clk_i(clk_i), .we_i(rot_we), .waddr_i(rot_waddr), .wdata_i(rot_wdata),
    .raddr_i(rot_raddr), .rdata_o(rot_rdata)
  );

  prc_ram #(.DEPTH(RotDepth), .WIDTH(7)) u_inv (
    .clk_i(clk_i), .we_i(inv_we), .waddr_i(inv_waddr), .wdata_i(inv_wdata),
    .raddr_i(inv_raddr), .rdata_o(inv_rdata)
  );

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    k_d         = k_q;
    a_d         = a_q;
    b_d         = b_q;
    v_d         = v_q;
    kidx_d      = kidx_q;
    j_d         = j_q;
    base_d      = base_q;
    sel_rot_d   = sel_rot_q;
    keyed_d     = keyed_q;
    pos_d       = pos_q;
    ph_d        = ph_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    draw_cmd    = '0;
    tmp         = '0;
    carry       = 1'b0;
    sv_we       = 1'b0;
    sv_waddr    = i_q;
    sv_wdata    = i_q;
    sv_raddr    = i_q;
    refl_we     = 1'b0;
    refl_waddr  = i_q;
    refl_wdata  = i_q;
    refl_raddr  = a_q;
    rot_we      = 1'b0;
    rot_waddr   = base_q + RAW'(i_q);
    rot_wdata   = i_q;
    rot_raddr   = base_q + RAW'(i_q);
    inv_we      = 1'b0;
    inv_waddr   = base_q + RAW'(rot_rdata);
    inv_wdata   = i_q;
    inv_raddr   = base_q + RAW'(v_q);

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.operation == OpRekey) begin
            draw_cmd.init = 1'b1;
            kidx_d  = '0;
            state_d = ST_MIX;
          end else if (in_data_i.in_char >= PrintLo && in_data_i.in_char <= PrintHi) begin
            v_d     = 7'(in_data_i.in_char - PrintLo);
            j_d     = '0;
            base_d  = '0;
            state_d = ST_TF;
          end else begin
            out_d.out_char       = in_data_i.in_char;
            out_d.passed_through = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_OUT;
          end
        end
      end
      ST_MIX: begin
        draw_cmd.mix = 1'b1;
        if (kidx_q == KeyLast) begin
          kidx_d  = '0;
          i_d     = '0;
          state_d = ST_FILL;
        end else begin
          kidx_d = kidx_q + 4'd1;
        end
      end
      ST_FILL: begin
        sv_we   = 1'b1;
        refl_we = 1'b1;
        if (i_q == RingLast) begin
          i_d       = '0;
          kidx_d    = '0;
          sel_rot_d = 1'b0;
          state_d   = ST_SDRAW;
        end else begin
          i_d = i_q + 7'd1;
        end
      end
      ST_SDRAW: begin
        draw_cmd.draw = 1'b1;
        kidx_d  = (kidx_q == KeyLast) ? 4'd0 : kidx_q + 4'd1;
        state_d = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (draw_done) begin
          k_d     = draw_k;
          state_d = ST_SRA;
        end
      end
      ST_SRA: begin
        state_d = ST_SRB;
      end
      ST_SRB: begin
        sv_raddr  = k_q;
        rot_raddr = base_q + RAW'(k_q);
        a_d       = swap_rdata;
        state_d   = ST_SWA;
      end
      ST_SWA: begin
        sv_we     = !sel_rot_q;
        rot_we    = sel_rot_q;
        sv_wdata  = swap_rdata;
        rot_wdata = swap_rdata;
        state_d   = ST_SWB;
      end
      ST_SWB: begin
        sv_we     = !sel_rot_q;
        rot_we    = sel_rot_q;
        sv_waddr  = k_q;
        rot_waddr = base_q + RAW'(k_q);
        sv_wdata  = a_q;
        rot_wdata = a_q;
        if (i_q == RingLast) begin
          i_d     = '0;
          state_d = sel_rot_q ? ST_INVA : ST_RRA;
        end else begin
          i_d     = i_q + 7'd1;
          state_d = ST_SDRAW;
        end
      end
      ST_RRA: begin
        state_d = ST_RRB;
      end
      ST_RRB: begin
        sv_raddr = i_q + 7'd1;
        a_d      = sv_rdata;
        state_d  = ST_RRC;
      end
      ST_RRC: begin
        b_d        = sv_rdata;
        refl_raddr = a_q;
        state_d    = ST_RRD;
      end
      ST_RRD: begin
        refl_raddr = b_q;
        k_d        = refl_rdata;
        state_d    = ST_RWA;
      end
      ST_RWA: begin
        refl_we    = 1'b1;
        refl_waddr = a_q;
        refl_wdata = refl_rdata;
        state_d    = ST_RWB;
      end
      ST_RWB: begin
        refl_we    = 1'b1;
        refl_waddr = b_q;
        refl_wdata = k_q;
        if (i_q == RingLast - 7'd1) begin
          i_d     = '0;
          j_d     = '0;
          base_d  = '0;
          state_d = ST_RFILL;
        end else begin
          i_d     = i_q + 7'd2;
          state_d = ST_RRA;
        end
      end
      ST_RFILL: begin
        rot_we = 1'b1;
        if (i_q == RingLast) begin
          i_d       = '0;
          kidx_d    = '0;
          sel_rot_d = 1'b1;
          state_d   = ST_SDRAW;
        end else begin
          i_d = i_q + 7'd1;
        end
      end
      ST_INVA: begin
        state_d = ST_INVB;
      end
      ST_INVB: begin
        inv_we = 1'b1;
        if (i_q == RingLast) begin
          i_d = '0;
          if (j_q == JLast) begin
            for (int n = 0; n < NUM_ROTORS; n++) begin
              pos_d[n] = '0;
            end
            ph_d        = '0;
            keyed_d     = 1'b1;
            out_d       = '0;
            out_valid_d = 1'b1;
            state_d     = ST_OUT;
          end else begin
            j_d     = j_q + JW'(1);
            base_d  = base_q + RowStep;
            state_d = ST_RFILL;
          end
        end else begin
          i_d     = i_q + 7'd1;
          state_d = ST_INVA;
        end
      end
      ST_TF: begin
        rot_raddr = base_q + RAW'(ring_wrap({1'b0, v_q} + {1'b0, pos_j}));
        state_d   = ST_TFD;
      end
      ST_TFD: begin
        v_d = keyed_q ? rot_rdata : 7'd0;
        if (j_q == JLast) begin
          state_d = ST_TR;
        end else begin
          j_d     = j_q + JW'(1);
          base_d  = base_q + RowStep;
          state_d = ST_TF;
        end
      end
      ST_TR: begin
        refl_raddr = ring_wrap({1'b0, v_q} + {1'b0, ph_q});
        state_d    = ST_TRD;
      end
      ST_TRD: begin
        tmp     = keyed_q ? refl_rdata : 7'd0;
        v_d     = ring_wrap({1'b0, tmp} + RingMod - {1'b0, ph_q});
        j_d     = JLast;
        base_d  = LastBase;
        state_d = ST_TB;
      end
      ST_TB: begin
        state_d = ST_TBD;
      end
      ST_TBD: begin
        tmp = keyed_q ? inv_rdata : 7'd0;
        tmp = ring_wrap({1'b0, tmp} + RingMod - {1'b0, pos_j});
        v_d = tmp;
        if (j_q == '0) begin
          carry = 1'b1;
          for (int n = 0; n < NUM_ROTORS; n++) begin
            if (carry) begin
              if (pos_q[n] == RingLast) begin
                pos_d[n] = '0;
              end else begin
                pos_d[n] = pos_q[n] + 7'd1;
                carry    = 1'b0;
              end
            end
          end
          ph_d                 = (ph_q == RingLast) ? 7'd0 : ph_q + 7'd1;
          out_d.out_char       = {1'b0, tmp} + PrintLo;
          out_d.passed_through = 1'b0;
          out_valid_d          = 1'b1;
          state_d              = ST_OUT;
        end else begin
          j_d     = j_q - JW'(1);
          base_d  = base_q - RowStep;
          state_d = ST_TB;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    a_q    <= a_d;
    b_q    <= b_d;
    v_q    <= v_d;
    base_q <= base_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      kidx_q      <= '0;
      j_q         <= '0;
      sel_rot_q   <= 1'b0;
      keyed_q     <= 1'b0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
      key_lo_q    <= '0;
      key_hi_q    <= '0;
      for (int n = 0; n < NUM_ROTORS; n++) begin
        pos_q[n] <= '0;
      end
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      kidx_q      <= kidx_d;
      j_q         <= j_d;
      sel_rot_q   <= sel_rot_d;
      keyed_q     <= keyed_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKeyLow:  key_lo_q <= cfg_data_i;
          CfgKeyHigh: key_hi_q <= cfg_data_i[39:0];
          default: ;
        endcase
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while result beat pending");

  a_draw_only_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_done |-> (state_q == ST_SWAIT)) else $error("draw finished outside wait");

  a_rekey_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.operation == OpRekey) |=> (state_q == ST_MIX))
    else $error("rekey did not start seed mixing");

  a_index_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (i_q <= RingLast && ph_q <= RingLast))
    else $error("ring index out of range");

endmodule

>>> tb/sv/printable_rotor_cipher_tb.sv
// Self-checking testbench for printable_rotor_cipher: directed table, then random
// rekey/transform traffic under several keys, checked against an in-bench cipher model.
// Depends on prc_pkg and the printable_rotor_cipher RTL.
module printable_rotor_cipher_tb;
  import prc_pkg::*;

  localparam int NumRotors = 4;
  localparam int Ring = 94;
  localparam int CycleLimit = 2000000;
  localparam int RandPerKey = 285;

  typedef struct {
    logic       op;
    logic [7:0] ch;
    bit         typed;
    prc_out_t   result;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  prc_in_t in_data = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CfgKeyLow;
  logic [63:0] cfg_data = '0;
  logic out_valid, in_stall;
  prc_out_t out_data;

  printable_rotor_cipher #(.NUM_ROTORS(NumRotors)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always #5 clk = ~clk;

  // cipher model state
  logic [63:0] key_lo = '0;
  logic [39:0] key_hi = '0;
  logic [6:0] rotor [NumRotors][Ring];
  logic [6:0] rotor_inv [NumRotors][Ring];
  logic [6:0] reflector [Ring];
  logic [6:0] shuffle [Ring];
  logic [6:0] position [NumRotors];
  logic [6:0] phase;
  int unsigned seed;

  prc_out_t pending_results[$];
  int unsigned accepted = 0;
  int errors = 0;
  int cycles = 0;
  bit cur_typed = 0;
  prc_out_t cur_result;
  int stall_pct = 0;

  initial begin
    for (int j = 0; j < NumRotors; j++) begin
      position[j] = '0;
      for (int i = 0; i < Ring; i++) begin
        rotor[j][i] = '0;
        rotor_inv[j][i] = '0;
      end
    end
    for (int i = 0; i < Ring; i++) begin
      reflector[i] = '0;
      shuffle[i] = '0;
    end
    phase = '0;
    seed = 0;
  end

  function automatic int unsigned key_byte(int unsigned n);
    if (n < 8) return 32'((key_lo >> (8 * n)) & 64'hff);
    return 32'((key_hi >> (8 * (n - 8))) & 40'hff);
  endfunction

  function automatic int unsigned draw_index(int unsigned i);
    seed = (5 * seed + key_byte(i % 13)) & 32'h7fff;
    return ((seed % 65521) & 32'h7fff) % Ring;
  endfunction

  function automatic void schedule_keys();
    int unsigned k;
    logic [6:0] t;
    seed = 123;
    for (int unsigned i = 0; i < 13; i++) seed = (seed * key_byte(i) + i) & 32'h7fff;
    for (int i = 0; i < Ring; i++) begin
      shuffle[i] = 7'(i);
      reflector[i] = 7'(i);
    end
    for (int unsigned i = 0; i < Ring; i++) begin
      k = draw_index(i);
      t = shuffle[k];
      shuffle[k] = shuffle[i];
      shuffle[i] = t;
    end
    for (int i = 0; i < Ring; i += 2) begin
      t = reflector[shuffle[i]];
      reflector[shuffle[i]] = reflector[shuffle[i + 1]];
      reflector[shuffle[i + 1]] = t;
    end
    for (int j = 0; j < NumRotors; j++) begin
      position[j] = '0;
      for (int i = 0; i < Ring; i++) rotor[j][i] = 7'(i);
      for (int unsigned i = 0; i < Ring; i++) begin
        k = draw_index(i);
        t = rotor[j][i];
        rotor[j][i] = rotor[j][k];
        rotor[j][k] = t;
      end
      for (int i = 0; i < Ring; i++) rotor_inv[j][rotor[j][i]] = 7'(i);
    end
    phase = '0;
  endfunction

  function automatic logic [7:0] encipher(logic [7:0] c);
    int unsigned v, ph;
    bit carry;
    v = c - 32;
    ph = phase;
    for (int j = 0; j < NumRotors; j++) v = rotor[j][(v + position[j]) % Ring] % Ring;
    v = (reflector[(v + ph) % Ring] % Ring + Ring - ph) % Ring;
    for (int j = NumRotors - 1; j >= 0; j--)
      v = (rotor_inv[j][v] % Ring + Ring - position[j]) % Ring;
    carry = 1;
    for (int j = 0; j < NumRotors; j++) begin
      if (carry) begin
        if (position[j] + 1 < Ring) begin
          position[j] = 7'(position[j] + 1);
          carry = 0;
        end else begin
          position[j] = '0;
        end
      end
    end
    phase = 7'((ph + 1) % Ring);
    return 8'(v + 32);
  endfunction

  function automatic prc_out_t cipher_step(prc_in_t item);
    prc_out_t r;
    if (item.operation == OpRekey) begin
      schedule_keys();
      r = '0;
    end else if (item.in_char >= PrintLo && item.in_char <= PrintHi) begin
      r.out_char = encipher(item.in_char);
      r.passed_through = 1'b0;
    end else begin
      r.out_char = item.in_char;
      r.passed_through = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    prc_out_t r;
    if (rst_n && in_valid && !in_stall) begin
      r = cipher_step(in_data);
      pending_results.push_back(cur_typed ? cur_result : r);
      accepted <= accepted + 1;
    end
  end

  always @(posedge clk) begin
    prc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_char !== want.out_char)
          $display("%0t: out_char expected %h actual %h", $time, want.out_char,
                   out_data.out_char);
        if (out_data.passed_through !== want.passed_through)
          $display("%0t: passed_through expected %b actual %b", $time,
                   want.passed_through, out_data.passed_through);
        if (out_data !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stall pattern, with stall-free stretches
  always @(negedge clk) begin
    if (cycles % 150 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  int burst_left = 0;

  task automatic send(logic op, logic [7:0] ch, bit typed, prc_out_t result);
    int unsigned n;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    n = accepted;
    in_data.operation = op;
    in_data.in_char = ch;
    cur_typed = typed;
    cur_result = result;
    in_valid = 1'b1;
    do @(negedge clk); while (accepted == n);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_key(logic [63:0] lo, logic [63:0] hi);
    wait_idle();
    cfg_we = 1'b1;
    cfg_idx = CfgKeyLow;
    cfg_data = lo;
    @(negedge clk);
    cfg_idx = CfgKeyHigh;
    cfg_data = hi;
    @(negedge clk);
    cfg_we = 1'b0;
    key_lo = lo;
    key_hi = hi[39:0];
  endtask

  row_t directed[$] = '{
    '{OpXform, 8'd32,  1'b0, '0},
    '{OpXform, 8'd125, 1'b0, '0},
    '{OpXform, 8'd0,   1'b1, '{8'd0, 1'b1}},
    '{OpXform, 8'd255, 1'b1, '{8'd255, 1'b1}},
    '{OpRekey, 8'd77,  1'b1, '{8'd0, 1'b0}},
    '{OpXform, 8'd32,  1'b0, '0},
    '{OpXform, 8'd125, 1'b0, '0},
    '{OpXform, 8'd31,  1'b1, '{8'd31, 1'b1}},
    '{OpXform, 8'd126, 1'b1, '{8'd126, 1'b1}},
    '{OpXform, 8'd65,  1'b0, '0},
    '{OpXform, 8'd128, 1'b1, '{8'd128, 1'b1}},
    '{OpXform, 8'd97,  1'b0, '0},
    '{OpRekey, 8'd255, 1'b1, '{8'd0, 1'b0}},
    '{OpXform, 8'd90,  1'b0, '0}
  };

  initial begin
    logic [63:0] lo, hi;
    logic op;
    logic [7:0] ch;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (directed[i]) send(directed[i].op, directed[i].ch, directed[i].typed,
                               directed[i].result);
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin lo = '0; hi = '0; end
        1: begin lo = '1; hi = '1; end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      write_key(lo, hi);
      send(OpRekey, 8'($urandom_range(0, 255)), 1'b0, '0);
      for (int n = 0; n < RandPerKey; n++) begin
        op = ($urandom_range(0, 59) == 0) ? OpRekey : OpXform;
        ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(32, 125));
        send(op, ch, 1'b0, '0);
      end
    end
    wait_idle();
    repeat (50) @(negedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/core/prc_pkg.sv
rtl/core/prc_ram.sv
rtl/core/prc_draw.sv
rtl/core/printable_rotor_cipher.sv
tb/sv/printable_rotor_cipher_tb.sv
